// ===== sv/icsc_pkg.sv =====
// Shared types and constants for the irregularly clocked stream cipher.
// No dependencies; imported by icsc_kg, irregular_clocked_stream_cipher and the testbench.
`timescale 1ns / 1ps

package icsc_pkg;

   // Register length of R and S
   localparam int unsigned REG_LEN = 100;

   // Feedback taps of R
   localparam logic [REG_LEN-1:0] R_TAPS  = {36'h3DF87818F, 64'hB55466601279327B};
   // Constants of the S nonlinear update
   localparam logic [REG_LEN-1:0] S_COMP0 = {36'h6057EBFEA, 64'h7942A8096AA97A30};
   localparam logic [REG_LEN-1:0] S_COMP1 = {36'h191C23DD7, 64'hE3A21D63DD629E9A};
   localparam logic [REG_LEN-1:0] S_FB0   = {36'h19CEC5802, 64'hAF4A93819FFA7FAF};
   localparam logic [REG_LEN-1:0] S_FB1   = {36'h840FBC52B, 64'h4911B0634C8CB877};
   // Nonlinear term covers bits 1..98 only
   localparam logic [REG_LEN-1:0] S_MID_MASK = {1'b0, {(REG_LEN-2){1'b1}}, 1'b0};

   // Key and IV lengths, setup schedule
   localparam int unsigned KEY_BITS     = 80;
   localparam int unsigned IV_BITS      = 80;
   localparam int unsigned SEED_BITS    = KEY_BITS + IV_BITS;
   localparam int unsigned PAD_CLOCKS   = 100;
   localparam int unsigned SETUP_CLOCKS = SEED_BITS + PAD_CLOCKS;
   localparam int unsigned BYTE_BITS    = 8;
   localparam int unsigned CNT_W        = $clog2(SETUP_CLOCKS);

   // Configuration register indexes
   localparam logic [1:0] CSR_KEY_HIGH = 2'd0;
   localparam logic [1:0] CSR_KEY_LOW  = 2'd1;
   localparam logic [1:0] CSR_IV_HIGH  = 2'd2;
   localparam logic [1:0] CSR_IV_LOW   = 2'd3;

   // Transaction function codes
   localparam logic FUNC_SETUP = 1'b0;
   localparam logic FUNC_DATA  = 1'b1;

   // Control from the sequencer to the generator
   typedef struct packed {
      logic clear;   // zero R and S
      logic step;    // one generator clock
      logic mix;     // mix S into the R input
      logic bit_in;  // input bit for this clock
   } kg_ctl_type;

endpackage

// ===== sv/icsc_kg.sv =====
// Keystream generator: R and S registers and one generator clock per cycle while step is set.
// Depends on icsc_pkg.
`timescale 1ns / 1ps

module icsc_kg (
   input  logic                clock,
   input  logic                reset,
   input  icsc_pkg::kg_ctl_type ctl,
   output logic                ks_bit
);
   import icsc_pkg::*;

   logic [REG_LEN-1:0] r_ff, r_in;
   logic [REG_LEN-1:0] s_ff, s_in;
   logic [REG_LEN-1:0] r_next, s_next, s_up, s_mid;
   logic               ctl_r, ctl_s, in_r, fb_r, fb_s;

   // One generator clock
   always_comb begin
      ctl_r = s_ff[34] ^ r_ff[67];
      ctl_s = r_ff[33] ^ s_ff[67];
      in_r  = ctl.bit_in ^ (ctl.mix & s_ff[50]);
      fb_r  = r_ff[REG_LEN-1] ^ in_r;
      fb_s  = s_ff[REG_LEN-1] ^ ctl.bit_in;

      r_next = {r_ff[REG_LEN-2:0], 1'b0};
      if (ctl_r) begin
         r_next = r_next ^ r_ff;
      end
      if (fb_r) begin
         r_next = r_next ^ R_TAPS;
      end

      s_up   = {1'b0, s_ff[REG_LEN-1:1]};
      s_mid  = (s_ff ^ S_COMP0) & (s_up ^ S_COMP1) & S_MID_MASK;
      s_next = {s_ff[REG_LEN-2:0], 1'b0} ^ s_mid;
      if (fb_s) begin
         s_next = s_next ^ (ctl_s ? S_FB1 : S_FB0);
      end
   end

   // Clear wins over step
   always_comb begin
      r_in = r_ff;
      s_in = s_ff;
      if (ctl.clear) begin
         r_in = '0;
         s_in = '0;
      end else if (ctl.step) begin
         r_in = r_next;
         s_in = s_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r_ff <= '0;
         s_ff <= '0;
      end else begin
         r_ff <= r_in;
         s_ff <= s_in;
      end
   end

   assign ks_bit = r_ff[0] ^ s_ff[0];

endmodule

// ===== sv/irregular_clocked_stream_cipher.sv =====
// Irregularly clocked stream cipher top level: sequencer, key/IV registers,
// result register. Depends on icsc_pkg and icsc_kg.
// The generator in icsc_kg runs one generator clock per cycle during setup
// and data. One transaction at a time: the next is taken only once the
// sequencer is back in idle, which is delayed while a finished result waits
// in done for a full result register.
// Reset: synchronous, clears R, S, key, IV, the sequencer state and the result valid flag.
`timescale 1ns / 1ps

module irregular_clocked_stream_cipher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_func,
   input  logic [7:0]  req_data_in,
   input  logic        req_end_of_buffer,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_data_out,
   output logic        rsp_setup_done,
   output logic        rsp_end_of_buffer_out,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata
);
   import icsc_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SETUP = 2'd1;
   localparam logic [1:0] ST_DATA  = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   logic [1:0]           state_ff, state_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 func_ff, func_in;
   logic [7:0]           din_ff, din_in;
   logic                 eob_ff, eob_in;
   logic [7:0]           ks_ff, ks_in;
   logic [SEED_BITS-1:0] seed_ff, seed_in;
   logic [15:0]          key_high_ff, iv_high_ff;
   logic [63:0]          key_low_ff, iv_low_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [7:0]           rsp_data_ff, rsp_data_in;
   logic                 rsp_setup_ff, rsp_setup_in;
   logic                 rsp_eob_ff, rsp_eob_in;

   kg_ctl_type kg_ctl;
   logic       ks_bit;
   logic       req_fire, slot_free, last_clk, finish;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
         iv_high_ff  <= '0;
         iv_low_ff   <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_KEY_HIGH: key_high_ff <= csr_wdata[15:0];
            CSR_KEY_LOW:  key_low_ff  <= csr_wdata;
            CSR_IV_HIGH:  iv_high_ff  <= csr_wdata[15:0];
            CSR_IV_LOW:   iv_low_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid & req_ready;
   assign slot_free = ~rsp_valid_ff | rsp_ready;

   // Generator control
   always_comb begin
      kg_ctl.clear  = req_fire & (req_func == FUNC_SETUP);
      kg_ctl.step   = (state_ff == ST_SETUP) | (state_ff == ST_DATA);
      kg_ctl.mix    = (state_ff == ST_SETUP);
      kg_ctl.bit_in = (state_ff == ST_SETUP) & seed_ff[SEED_BITS-1];
   end

   icsc_kg u_kg (
      .clock  (clock),
      .reset  (reset),
      .ctl    (kg_ctl),
      .ks_bit (ks_bit)
   );

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      func_in      = func_ff;
      din_in       = din_ff;
      eob_in       = eob_ff;
      ks_in        = ks_ff;
      seed_in      = seed_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_data_in  = rsp_data_ff;
      rsp_setup_in = rsp_setup_ff;
      rsp_eob_in   = rsp_eob_ff;
      last_clk     = 1'b0;
      finish       = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               func_in = req_func;
               din_in  = req_data_in;
               eob_in  = req_end_of_buffer;
               cnt_in  = '0;
               // IV bits go in first, then key bits, each MSB first
               seed_in = {iv_high_ff, iv_low_ff, key_high_ff, key_low_ff};
               state_in = (req_func == FUNC_SETUP) ? ST_SETUP : ST_DATA;
            end
         end
         ST_SETUP: begin
            // zeros shift in behind the seed for the padding clocks
            seed_in  = {seed_ff[SEED_BITS-2:0], 1'b0};
            cnt_in   = cnt_ff + 1'b1;
            last_clk = (cnt_ff == CNT_W'(SETUP_CLOCKS - 1));
         end
         ST_DATA: begin
            ks_in    = {ks_ff[6:0], ks_bit};
            cnt_in   = cnt_ff + 1'b1;
            last_clk = (cnt_ff == CNT_W'(BYTE_BITS - 1));
         end
         ST_DONE: begin
            finish = 1'b1;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Leave the work states; park in done while the result slot is full
      if (last_clk) begin
         finish   = 1'b1;
         state_in = ST_DONE;
      end
      if (finish & slot_free) begin
         state_in     = ST_IDLE;
         rsp_valid_in = 1'b1;
         rsp_setup_in = (func_ff == FUNC_SETUP);
         rsp_data_in  = (func_ff == FUNC_SETUP) ? 8'h00 : (din_ff ^ ks_in);
         rsp_eob_in   = eob_ff;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and working registers
   always_ff @(posedge clock) begin
      cnt_ff       <= cnt_in;
      func_ff      <= func_in;
      din_ff       <= din_in;
      eob_ff       <= eob_in;
      ks_ff        <= ks_in;
      seed_ff      <= seed_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_setup_ff <= rsp_setup_in;
      rsp_eob_ff   <= rsp_eob_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_data_out          = rsp_data_ff;
   assign rsp_setup_done        = rsp_setup_ff;
   assign rsp_end_of_buffer_out = rsp_eob_ff;

   // Checks
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff != ST_IDLE))
      else $error("sequencer idle after accepting a transaction");

   a_setup_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SETUP) |-> (cnt_ff < CNT_W'(SETUP_CLOCKS)))
      else $error("setup counter overran");

   a_data_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DATA) |-> (cnt_ff < CNT_W'(BYTE_BITS)))
      else $error("byte counter overran");

   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) != ST_IDLE))
      else $error("result raised without a transaction in work");

   a_setup_zero_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_setup_ff) |-> (rsp_data_ff == 8'h00))
      else $error("setup result carries data");

endmodule

// ===== tb/irregular_clocked_stream_cipher_test.sv =====
// Testbench for irregular_clocked_stream_cipher: directed and random traffic, checked
// against a bit-level keystream predictor. Depends on icsc_pkg and the cipher RTL.
`timescale 1ns / 1ps

module irregular_clocked_stream_cipher_test;
   import icsc_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int HOLD_CYCLES = 600;

   typedef struct packed {
      logic [7:0] data_out;
      logic       setup_done;
      logic       end_of_buffer_out;
   } cipher_result_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_func = FUNC_DATA;
   logic [7:0]  req_data_in = '0;
   logic        req_end_of_buffer = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_data_out;
   logic        rsp_setup_done;
   logic        rsp_end_of_buffer_out;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = CSR_KEY_HIGH;
   logic [63:0] csr_wdata = '0;

   // Predictor state: generator registers and the key/IV register copies
   logic [REG_LEN-1:0] gen_r = '0;
   logic [REG_LEN-1:0] gen_s = '0;
   logic [15:0]        key_high_q = '0;
   logic [63:0]        key_low_q = '0;
   logic [15:0]        iv_high_q = '0;
   logic [63:0]        iv_low_q = '0;

   cipher_result_type expected_q[$];
   int error_count = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int rsp_idle_pct = 0;
   int hold_left = 0;
   logic hold_req = 1'b0;

   irregular_clocked_stream_cipher u_top (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_func              (req_func),
      .req_data_in           (req_data_in),
      .req_end_of_buffer     (req_end_of_buffer),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_data_out          (rsp_data_out),
      .rsp_setup_done        (rsp_setup_done),
      .rsp_end_of_buffer_out (rsp_end_of_buffer_out),
      .csr_we                (csr_we),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Keystream predictor
   // ---------------------------------------------------------------------

   // R: shift, optional self-XOR under control, tap XOR on feedback
   function automatic void step_r(logic bit_in, logic ctl);
      logic               fb;
      logic [REG_LEN-1:0] nxt;
      fb  = gen_r[REG_LEN-1] ^ bit_in;
      nxt = gen_r << 1;
      if (ctl) nxt ^= gen_r;
      if (fb) nxt ^= R_TAPS;
      gen_r = nxt;
   endfunction

   // S: shift plus nonlinear middle term, feedback word picked by control
   function automatic void step_s(logic bit_in, logic ctl);
      logic               fb;
      logic [REG_LEN-1:0] nxt;
      fb  = gen_s[REG_LEN-1] ^ bit_in;
      nxt = (gen_s << 1) ^ ((gen_s ^ S_COMP0) & ((gen_s >> 1) ^ S_COMP1) & S_MID_MASK);
      if (fb) nxt ^= ctl ? S_FB1 : S_FB0;
      gen_s = nxt;
   endfunction

   // One generator clock; control bits taken from both registers beforehand
   function automatic void clock_generator(logic mix, logic bit_in);
      logic ctl_r, ctl_s, in_r;
      ctl_r = gen_s[34] ^ gen_r[67];
      ctl_s = gen_r[33] ^ gen_s[67];
      in_r  = bit_in ^ (mix & gen_s[50]);
      step_r(in_r, ctl_r);
      step_s(bit_in, ctl_s);
   endfunction

   // Expected result of one accepted transaction; advances the generator
   function automatic cipher_result_type predict_cipher(logic func, logic [7:0] din,
                                                        logic eob);
      cipher_result_type res;
      logic [79:0]       iv_word;
      logic [79:0]       key_word;
      logic [7:0]        ks;
      iv_word  = {iv_high_q, iv_low_q};
      key_word = {key_high_q, key_low_q};
      ks = '0;
      if (func == FUNC_SETUP) begin
         gen_r = '0;
         gen_s = '0;
         for (int i = 0; i < IV_BITS; i++) clock_generator(1'b1, iv_word[IV_BITS-1-i]);
         for (int i = 0; i < KEY_BITS; i++) clock_generator(1'b1, key_word[KEY_BITS-1-i]);
         for (int i = 0; i < PAD_CLOCKS; i++) clock_generator(1'b1, 1'b0);
         res.data_out   = '0;
         res.setup_done = 1'b1;
      end else begin
         // keystream bit is sampled before each clock, MSB first
         for (int i = 0; i < BYTE_BITS; i++) begin
            ks = {ks[6:0], gen_r[0] ^ gen_s[0]};
            clock_generator(1'b0, 1'b0);
         end
         res.data_out   = din ^ ks;
         res.setup_done = 1'b0;
      end
      res.end_of_buffer_out = eob;
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // Result side: ready generation with long hold-off, and checking
   // ---------------------------------------------------------------------

   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (hold_req) begin
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      cipher_result_type exp_res;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_q.size() == 0) begin
            $error("unexpected result transaction: data_out %0h", rsp_data_out);
            error_count++;
         end else begin
            exp_res = expected_q.pop_front();
            if (rsp_data_out !== exp_res.data_out) begin
               $error("data_out: expected %0h, got %0h", exp_res.data_out, rsp_data_out);
               error_count++;
            end
            if (rsp_setup_done !== exp_res.setup_done) begin
               $error("setup_done: expected %0b, got %0b", exp_res.setup_done, rsp_setup_done);
               error_count++;
            end
            if (rsp_end_of_buffer_out !== exp_res.end_of_buffer_out) begin
               $error("end_of_buffer_out: expected %0b, got %0b",
                      exp_res.end_of_buffer_out, rsp_end_of_buffer_out);
               error_count++;
            end
         end
      end
   end

   // Run-away guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Request side helpers
   // ---------------------------------------------------------------------

   // Offer one transaction, with an optional idle gap first; valid held until taken
   task automatic send_item(logic func, logic [7:0] din, logic eob);
      int gap;
      gap = 0;
      if ($urandom_range(99) < send_idle_pct)
         gap = ($urandom_range(9) == 0) ? $urandom_range(12, 30) : $urandom_range(1, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_func          <= func;
      req_data_in       <= din;
      req_end_of_buffer <= eob;
      do @(posedge clock); while (!req_ready);
      expected_q.push_back(predict_cipher(func, din, eob));
   endtask

   // Stop offering and wait until every expected result is back, then settle
   task automatic drain();
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Register write; csr_we left high so back-to-back writes need no toggle
   task automatic csr_write(logic [1:0] idx, logic [63:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         CSR_KEY_HIGH: key_high_q = value[15:0];
         CSR_KEY_LOW:  key_low_q  = value;
         CSR_IV_HIGH:  iv_high_q  = value[15:0];
         CSR_IV_LOW:   iv_low_q   = value;
         default: ;
      endcase
   endtask

   task automatic set_key_iv(logic [63:0] kh, logic [63:0] kl, logic [63:0] ih, logic [63:0] il);
      csr_write(CSR_KEY_HIGH, kh);
      csr_write(CSR_KEY_LOW, kl);
      csr_write(CSR_IV_HIGH, ih);
      csr_write(CSR_IV_LOW, il);
      csr_we <= 1'b0;
   endtask

   // Random word with the extremes weighted in
   function automatic logic [63:0] pick_word();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // Rewrite a random subset of the key/IV registers
   task automatic load_random_config();
      logic wrote;
      wrote = 1'b0;
      if ($urandom_range(3) != 0) begin csr_write(CSR_KEY_HIGH, pick_word()); wrote = 1'b1; end
      if ($urandom_range(3) != 0) begin csr_write(CSR_KEY_LOW, pick_word()); wrote = 1'b1; end
      if ($urandom_range(3) != 0) begin csr_write(CSR_IV_HIGH, pick_word()); wrote = 1'b1; end
      if ($urandom_range(3) != 0) begin csr_write(CSR_IV_LOW, pick_word()); wrote = 1'b1; end
      if (wrote) csr_we <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Data straight after reset runs the generator from the all-zero state
   task automatic test_data_before_setup();
      send_item(FUNC_DATA, 8'h00, 1'b0);
      send_item(FUNC_DATA, 8'hFF, 1'b1);
      send_item(FUNC_DATA, 8'h5A, 1'b0);
   endtask

   // All-zero and all-one key/IV, extreme data bytes
   task automatic test_key_extremes();
      drain();
      set_key_iv('0, '0, '0, '0);
      send_item(FUNC_SETUP, 8'hFF, 1'b1);
      send_item(FUNC_DATA, 8'h00, 1'b0);
      send_item(FUNC_DATA, 8'hFF, 1'b1);
      drain();
      set_key_iv('1, '1, '1, '1);
      send_item(FUNC_SETUP, 8'h00, 1'b0);
      send_item(FUNC_DATA, 8'h00, 1'b1);
      send_item(FUNC_DATA, 8'hFF, 1'b0);
      send_item(FUNC_DATA, 8'hA5, 1'b1);
   endtask

   // A register write must not disturb the running stream until the next setup
   task automatic test_config_latched_at_setup();
      drain();
      set_key_iv(64'h1234, 64'h0123456789ABCDEF, 64'hFEDC, 64'hBA98765432100123);
      send_item(FUNC_SETUP, 8'h3C, 1'b0);
      send_item(FUNC_DATA, 8'h11, 1'b0);
      drain();
      csr_write(CSR_KEY_HIGH, 64'hFFFF_FFFF_FFFF_8001);
      csr_we <= 1'b0;
      send_item(FUNC_DATA, 8'h22, 1'b0);
      send_item(FUNC_DATA, 8'h33, 1'b1);
      send_item(FUNC_SETUP, 8'h00, 1'b0);
      send_item(FUNC_DATA, 8'h44, 1'b1);
   endtask

   // Consecutive setups restart from the same key and IV
   task automatic test_back_to_back_setup();
      send_item(FUNC_SETUP, 8'h00, 1'b1);
      send_item(FUNC_SETUP, 8'hFF, 1'b0);
      send_item(FUNC_DATA, 8'h80, 1'b1);
   endtask

   // Data bursts with random content, some led by a fresh key/IV and setup, plus stray setups
   task automatic test_random(int n_items, int send_pct, int rsp_pct);
      int sent, len, pick;
      send_idle_pct = send_pct;
      rsp_idle_pct  = rsp_pct;
      sent = 0;
      while (sent < n_items) begin
         pick = $urandom_range(99);
         if (pick < 10) begin
            drain();
            load_random_config();
            send_item(FUNC_SETUP, 8'($urandom), 1'($urandom));
            sent++;
         end else if (pick < 14) begin
            send_item(FUNC_SETUP, 8'($urandom), 1'($urandom));
            sent++;
         end
         len = $urandom_range(1, 40);
         for (int k = 0; k < len; k++) begin
            send_item(FUNC_DATA, 8'($urandom),
                      (k == len - 1) || ($urandom_range(15) == 0));
            sent++;
         end
      end
   endtask

   // Receiver holds off for a long stretch while the sender keeps offering
   task automatic test_backpressure();
      drain();
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      hold_req <= 1'b1;
      @(posedge clock);
      hold_req <= 1'b0;
      for (int k = 0; k < 30; k++) send_item(FUNC_DATA, 8'($urandom), k == 29);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 23;
      rsp_idle_pct  = 51;
      test_data_before_setup();
      test_key_extremes();
      test_config_latched_at_setup();
      test_back_to_back_setup();

      test_random(415, 23, 51);
      test_random(415, 51, 23);
      test_random(415, 0, 0);
      test_backpressure();

      drain();
      repeat (SETUP_CLOCKS + 40) @(posedge clock);
      if (error_count == 0 && expected_q.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
